>>> src/hbd_pkg.sv
// Shared types, constants and helpers for the Huffman bit decoder.
// No dependencies.
package hbd_pkg;

    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int GROUP_SIZE   = 16;
    localparam int GROUP_IDX_W  = 4;
    localparam int RESULT_LIMIT = 32;
    localparam int RES_CNT_W    = 6;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD    = 2'd0;
    localparam op_t OP_DECODE  = 2'd1;
    localparam op_t OP_RESTART = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_GRP   = 6'b001000,
        ST_SEL   = 6'b010000,
        ST_END   = 6'b100000
    } state_t;

    typedef struct packed {
        logic                   any;
        logic [GROUP_IDX_W-1:0] idx;
    } grp_hit_t;

    function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        m = '0;
        if (len >= LEN_W'(CODE_W))
        begin
            m = '1;
        end
        else
        begin
            m = (CODE_W'(1) << len) - CODE_W'(1);
        end
        return m;
    endfunction

endpackage

>>> src/hbd_cell.sv
// One code table entry with its own exact-match compare against the partial code.
// Depends on hbd_pkg.
module hbd_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  logic [hbd_pkg::CODE_W-1:0]  load_code,
    input  logic [hbd_pkg::LEN_W-1:0]   load_len,
    input  logic                        cmp_en,
    input  logic [hbd_pkg::CODE_W-1:0]  partial_code,
    input  logic [hbd_pkg::LEN_W-1:0]   partial_len,
    output logic                        hit
);

    logic [hbd_pkg::CODE_W-1:0] code_reg;
    logic [hbd_pkg::LEN_W-1:0]  len_reg;
    logic                       hit_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            code_reg <= load_code & hbd_pkg::low_mask(load_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (load_en)
            begin
                len_reg <= load_len;
            end
            if (cmp_en)
            begin
                hit_reg <= (len_reg != '0) && (len_reg == partial_len)
                           && (code_reg == partial_code);
            end
        end
    end

    assign hit = hit_reg;

endmodule

>>> src/hbd_group.sv
// Registered find-first over one group of cell hit flags.
// Depends on hbd_pkg.
module hbd_group (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [hbd_pkg::GROUP_SIZE-1:0]      hits,
    output hbd_pkg::grp_hit_t                   result
);

    hbd_pkg::grp_hit_t res_reg;
    hbd_pkg::grp_hit_t res_next;

    always_comb
    begin
        res_next = '0;
        for (int i = hbd_pkg::GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                res_next.any = 1'b1;
                res_next.idx = hbd_pkg::GROUP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

>>> src/huffman_bit_decoder_top.sv
// Huffman bit decoder top level: code table cells, group encoders and bit sequencer.
// Depends on hbd_pkg, hbd_cell and hbd_group.
//
// A decode beat walks each stream bit through shift, parallel compare in every table
// cell, group priority pick and final pick, then hands over the last result. in_ready
// is low while a word is being decoded. Results leave through an output register, so
// a stalled output holds the decode at the next result; bit_count above WORD_BITS
// saturates to WORD_BITS. The table is cleared at reset with no sweep.
module huffman_bit_decoder_top #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32,
    parameter int WORD_BITS     = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [7:0]           entry_symbol,
    input  logic [31:0]          entry_code,
    input  logic [5:0]           entry_length,
    input  logic [WORD_BITS-1:0] data_word,
    input  logic [5:0]           bit_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           symbol,
    output logic                 code_error,
    output logic                 last
);

    localparam int NGROUP = (SYMBOL_COUNT + hbd_pkg::GROUP_SIZE - 1) / hbd_pkg::GROUP_SIZE;
    localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int PADDED = NGROUP * hbd_pkg::GROUP_SIZE;

    hbd_pkg::state_t              state_reg, state_next;
    logic [WORD_BITS-1:0]         word_reg, word_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [hbd_pkg::CODE_W-1:0]   pcode_reg, pcode_next;
    logic [hbd_pkg::LEN_W-1:0]    plen_reg, plen_next;
    logic [hbd_pkg::RES_CNT_W-1:0] nres_reg, nres_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [hbd_pkg::SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                         pend_err_reg, pend_err_next;
    logic                         ov_reg, ov_next;
    logic [hbd_pkg::SYM_W-1:0]    osym_reg, osym_next;
    logic                         oerr_reg, oerr_next;
    logic                         olast_reg, olast_next;

    logic                         accept;
    logic                         load_ok;
    logic                         cmp_en;
    logic                         grp_en;
    logic [PADDED-1:0]            hits;
    hbd_pkg::grp_hit_t            grp_res [NGROUP];
    logic                         found;
    logic [GW-1:0]                sel_grp;
    logic [hbd_pkg::GROUP_IDX_W-1:0] sel_idx;
    logic                         res_make;
    logic                         slot_free;
    logic [hbd_pkg::SYM_W-1:0]    new_sym;

    assign in_ready = (state_reg == hbd_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_ok  = accept && (operation == hbd_pkg::OP_LOAD)
                      && ({1'b0, entry_symbol} < 9'(SYMBOL_COUNT));
    assign cmp_en   = (state_reg == hbd_pkg::ST_CMP);
    assign grp_en   = (state_reg == hbd_pkg::ST_GRP);

    genvar g;
    generate
        for (g = 0; g < PADDED; g++)
        begin : g_cell
            if (g < SYMBOL_COUNT)
            begin : g_real
                hbd_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .load_en      (load_ok && (entry_symbol == 8'(g))),
                    .load_code    (entry_code),
                    .load_len     (entry_length),
                    .cmp_en       (cmp_en),
                    .partial_code (pcode_reg),
                    .partial_len  (plen_reg),
                    .hit          (hits[g])
                );
            end
            else
            begin : g_pad
                assign hits[g] = 1'b0;
            end
        end
        for (g = 0; g < NGROUP; g++)
        begin : g_grp
            hbd_group u_group (
                .clk    (clk),
                .rst_n  (rst_n),
                .en     (grp_en),
                .hits   (hits[g*hbd_pkg::GROUP_SIZE +: hbd_pkg::GROUP_SIZE]),
                .result (grp_res[g])
            );
        end
    endgenerate

    always_comb
    begin
        found   = 1'b0;
        sel_grp = '0;
        sel_idx = '0;
        for (int i = NGROUP - 1; i >= 0; i--)
        begin
            if (grp_res[i].any)
            begin
                found   = 1'b1;
                sel_grp = GW'(i);
                sel_idx = grp_res[i].idx;
            end
        end
    end

    assign new_sym   = hbd_pkg::SYM_W'({sel_grp, sel_idx});
    assign res_make  = found || (plen_reg >= hbd_pkg::LEN_W'(MAX_CODE_BITS));
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pcode_next      = pcode_reg;
        plen_next       = plen_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        ov_next         = ov_reg && !out_ready;
        osym_next       = osym_reg;
        oerr_next       = oerr_reg;
        olast_next      = olast_reg;
        case (state_reg)
            hbd_pkg::ST_IDLE:
            begin
                if (accept && (operation == hbd_pkg::OP_RESTART))
                begin
                    pcode_next = '0;
                    plen_next  = '0;
                end
                if (accept && (operation == hbd_pkg::OP_DECODE))
                begin
                    word_next = data_word;
                    idx_next  = '0;
                    nres_next = '0;
                    if ({1'b0, bit_count} > 7'(WORD_BITS))
                    begin
                        cnt_next = CNT_W'(WORD_BITS);
                    end
                    else
                    begin
                        cnt_next = CNT_W'(bit_count);
                    end
                    if (bit_count != '0)
                    begin
                        state_next = hbd_pkg::ST_SHIFT;
                    end
                end
            end
            hbd_pkg::ST_SHIFT:
            begin
                pcode_next = {pcode_reg[hbd_pkg::CODE_W-2:0], word_reg[WORD_BITS-1]};
                word_next  = word_reg << 1;
                plen_next  = plen_reg + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = hbd_pkg::ST_CMP;
            end
            hbd_pkg::ST_CMP:
            begin
                state_next = hbd_pkg::ST_GRP;
            end
            hbd_pkg::ST_GRP:
            begin
                state_next = hbd_pkg::ST_SEL;
            end
            hbd_pkg::ST_SEL:
            begin
                if (!res_make || !pend_valid_reg || slot_free
                    || (nres_reg >= hbd_pkg::RES_CNT_W'(hbd_pkg::RESULT_LIMIT)))
                begin
                    if (res_make)
                    begin
                        pcode_next = '0;
                        plen_next  = '0;
                        if (nres_reg < hbd_pkg::RES_CNT_W'(hbd_pkg::RESULT_LIMIT))
                        begin
                            if (pend_valid_reg)
                            begin
                                ov_next    = 1'b1;
                                osym_next  = pend_sym_reg;
                                oerr_next  = pend_err_reg;
                                olast_next = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_sym_next   = found ? new_sym : '0;
                            pend_err_next   = !found;
                            nres_next       = nres_reg + 1'b1;
                        end
                    end
                    if (idx_reg == cnt_reg)
                    begin
                        state_next = hbd_pkg::ST_END;
                    end
                    else
                    begin
                        state_next = hbd_pkg::ST_SHIFT;
                    end
                end
            end
            hbd_pkg::ST_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = hbd_pkg::ST_IDLE;
                end
                else if (slot_free)
                begin
                    ov_next         = 1'b1;
                    osym_next       = pend_sym_reg;
                    oerr_next       = pend_err_reg;
                    olast_next      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = hbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        nres_reg     <= nres_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        osym_reg     <= osym_next;
        oerr_reg     <= oerr_next;
        olast_reg    <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hbd_pkg::ST_IDLE;
            pcode_reg      <= '0;
            plen_reg       <= '0;
            pend_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pcode_reg      <= pcode_next;
            plen_reg       <= plen_next;
            pend_valid_reg <= pend_valid_next;
            ov_reg         <= ov_next;
        end
    end

    assign out_valid  = ov_reg;
    assign symbol     = osym_reg;
    assign code_error = oerr_reg;
    assign last       = olast_reg;

endmodule

>>> src/hbd_checker.sv
// Port-level checks for the Huffman bit decoder, bound to the top level.
// Depends on hbd_pkg and huffman_bit_decoder_top.
module hbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] operation,
    input logic [5:0] bit_count,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] symbol,
    input logic       code_error,
    input logic       last
);

    a_err_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_error) |-> (symbol == 8'd0))
        else $error("error beat carries a non-zero symbol");

    a_busy_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == hbd_pkg::OP_DECODE) && (bit_count != 6'd0))
        |=> !in_ready)
        else $error("decoder took a new beat while decoding a word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(symbol)
        && $stable(code_error) && $stable(last)))
        else $error("stalled result beat changed");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |-> !in_ready)
        else $error("word ended without a last result");

endmodule

bind huffman_bit_decoder_top hbd_checker u_hbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .bit_count  (bit_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .code_error (code_error),
    .last       (last)
);
